@@ rtl/pvi_pkg.sv @@
// Shared constants, types and helper functions of the polar vertex interpolator.
`default_nettype none

package pvi_pkg;

   // Field widths
   localparam int CW       = 16;            // coordinate width, signed
   localparam int FB       = 12;            // coordinate fraction bits
   localparam int STEPS    = 16;            // CORDIC iterations
   localparam int SCALE_SH = 30;            // CORDIC working scale
   localparam int AW       = 32;            // binary angle width, one turn = 2^AW
   localparam int TW       = 16;            // blend weight width
   localparam int COLW     = 32;            // packed color width
   localparam int CHW      = 8;             // color channel width
   localparam int NCH      = COLW / CHW;    // color channels
   localparam int KW       = 31;            // inverse gain width

   // Datapath widths
   localparam int DW          = CW + SCALE_SH + 3;   // CORDIC x/y width
   localparam int ZW          = AW + 2;              // signed rotation angle width
   localparam int SQW         = 2 * CW;              // sum of squares width
   localparam int POLAR_STEPS = (STEPS > CW) ? STEPS : CW;

   // Pipeline latencies, counted from the input register
   localparam int LAT_POLAR = POLAR_STEPS + 1;
   localparam int LAT_ROT   = STEPS + 4;
   localparam int LAT_CORE  = LAT_POLAR + LAT_ROT;

   // Angle constants
   localparam logic [AW-1:0] QUARTER_TURN  = AW'(64'h4000_0000);
   localparam logic [AW-1:0] THREE_QUARTER = AW'(64'hC000_0000);

   // Rounding constants
   localparam int ROUND_HALF = 1 << (TW - 1);
   localparam logic signed [DW-1:0] ROUND_SCALE = DW'(longint'(1) <<< (SCALE_SH - 1));

   // Coordinate limits
   localparam logic signed [DW-1:0] COORD_HI = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [DW-1:0] COORD_LO = {{(DW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   // Arctangent of 2^-i in binary angle units
   localparam logic [AW-1:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic [COLW-1:0]      color;
   } lin_type;

   typedef struct packed {
      logic                 clip;
      logic signed [CW-1:0] value;
   } sat_type;

   // Square root of the accumulated CORDIC gain, Q60 in, Q30 out
   function automatic longint unsigned gain_root();
      longint unsigned p;
      longint unsigned n;
      longint unsigned res;
      longint unsigned b;
      int i;
      p = 64'd1 << 60;
      for (i = 0; i < STEPS; i++) begin
         p = p + (p >> ((2 * i) & 63));
      end
      n   = p;
      res = 64'd0;
      b   = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   localparam longint unsigned GAIN_ROOT     = gain_root();
   localparam longint unsigned INV_GAIN_FULL = ((64'd1 << 60) + GAIN_ROOT / 2) / GAIN_ROOT;
   localparam logic [KW-1:0]   INV_GAIN      = INV_GAIN_FULL[KW-1:0];

   // Clamp a wide value to the coordinate range
   function automatic sat_type sat_coord(input logic signed [DW-1:0] v);
      sat_type s;
      if (v > COORD_HI) begin
         s.clip  = 1'b1;
         s.value = COORD_HI[CW-1:0];
      end else if (v < COORD_LO) begin
         s.clip  = 1'b1;
         s.value = COORD_LO[CW-1:0];
      end else begin
         s.clip  = 1'b0;
         s.value = v[CW-1:0];
      end
      return s;
   endfunction

   // z in polar mode: 1.0, clamped if not representable
   localparam sat_type Z_ONE = sat_coord(DW'(longint'(1)) <<< FB);

endpackage

`default_nettype wire

@@ rtl/pvi_channels.sv @@
// Channel interfaces of the polar vertex interpolator: request, response, register write.
`default_nettype none

interface pvi_req_if;
   import pvi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] start_x;
   logic signed [CW-1:0] start_y;
   logic signed [CW-1:0] start_z;
   logic signed [CW-1:0] end_x;
   logic signed [CW-1:0] end_y;
   logic signed [CW-1:0] end_z;
   logic [COLW-1:0]      start_color;
   logic [COLW-1:0]      end_color;
   logic [TW-1:0]        blend;
   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   start_color, end_color, blend, input ready);
   modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   start_color, end_color, blend, output ready);
endinterface

interface pvi_rsp_if;
   import pvi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] out_x;
   logic signed [CW-1:0] out_y;
   logic signed [CW-1:0] out_z;
   logic [COLW-1:0]      out_color;
   logic                 clipped;
   modport source (output valid, out_x, out_y, out_z, out_color, clipped, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_color, clipped, output ready);
endinterface

interface pvi_csr_if;
   logic valid;
   logic ready;
   logic blend_mode;
   modport source (output valid, blend_mode, input ready);
   modport sink   (input valid, blend_mode, output ready);
endinterface

`default_nettype wire

@@ rtl/pvi_polar.sv @@
// Pipelined cartesian to polar conversion: CORDIC vectoring angle and integer square root.
`default_nettype none

module pvi_polar (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [pvi_pkg::CW-1:0] x,
   input  logic signed [pvi_pkg::CW-1:0] y,
   output logic [pvi_pkg::AW-1:0]       angle,
   output logic [pvi_pkg::CW-1:0]       mag
);
   import pvi_pkg::*;

   logic signed [DW-1:0] cx_ff   [POLAR_STEPS+1];
   logic signed [DW-1:0] cy_ff   [POLAR_STEPS+1];
   logic [AW-1:0]        z_ff    [POLAR_STEPS+1];
   logic                 zero_ff [POLAR_STEPS+1];
   logic [SQW-1:0]       n_ff    [POLAR_STEPS+1];
   logic [SQW-1:0]       res_ff  [POLAR_STEPS+1];

   logic signed [DW-1:0]  xs;
   logic signed [DW-1:0]  ys;
   logic signed [DW-1:0]  cx_in;
   logic signed [DW-1:0]  cy_in;
   logic [AW-1:0]         z_in;
   logic signed [SQW-1:0] sq_x;
   logic signed [SQW-1:0] sq_y;
   logic [SQW-1:0]        sq_sum;

   // Scale the vector and fold the lower half plane by a quarter or three-quarter turn
   always_comb begin
      xs     = {{(DW-CW){x[CW-1]}}, x} <<< SCALE_SH;
      ys     = {{(DW-CW){y[CW-1]}}, y} <<< SCALE_SH;
      sq_x   = x * x;
      sq_y   = y * y;
      sq_sum = $unsigned(sq_x) + $unsigned(sq_y);
      cx_in  = ys;
      cy_in  = xs;
      z_in   = '0;
      if (y[CW-1]) begin
         if (!x[CW-1]) begin
            cx_in = xs;
            cy_in = -ys;
            z_in  = QUARTER_TURN;
         end else begin
            cx_in = -xs;
            cy_in = ys;
            z_in  = THREE_QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]   <= cx_in;
         cy_ff[0]   <= cy_in;
         z_ff[0]    <= z_in;
         zero_ff[0] <= (x == '0) && (y == '0);
         n_ff[0]    <= sq_sum;
         res_ff[0]  <= '0;
      end
   end

   // One CORDIC micro-rotation and one root digit per stage
   for (genvar i = 0; i < POLAR_STEPS; i++) begin : g_step
      localparam int BIT_SH = (i < CW) ? (SQW - 2 - 2 * i) : 0;
      localparam logic [SQW-1:0] BIT = SQW'(64'd1 << BIT_SH);

      logic signed [DW-1:0] cx_nx;
      logic signed [DW-1:0] cy_nx;
      logic [AW-1:0]        z_nx;
      logic [SQW-1:0]       n_nx;
      logic [SQW-1:0]       res_nx;
      logic [SQW-1:0]       trial;

      always_comb begin
         cx_nx  = cx_ff[i];
         cy_nx  = cy_ff[i];
         z_nx   = z_ff[i];
         n_nx   = n_ff[i];
         res_nx = res_ff[i];
         trial  = res_ff[i] + BIT;
         if (i < STEPS) begin
            if (!cy_ff[i][DW-1]) begin
               cx_nx = cx_ff[i] + (cy_ff[i] >>> i);
               cy_nx = cy_ff[i] - (cx_ff[i] >>> i);
               z_nx  = z_ff[i] + ATAN_TAB[i];
            end else begin
               cx_nx = cx_ff[i] - (cy_ff[i] >>> i);
               cy_nx = cy_ff[i] + (cx_ff[i] >>> i);
               z_nx  = z_ff[i] - ATAN_TAB[i];
            end
         end
         if (i < CW) begin
            if (n_ff[i] >= trial) begin
               n_nx   = n_ff[i] - trial;
               res_nx = (res_ff[i] >> 1) + BIT;
            end else begin
               res_nx = res_ff[i] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i+1]   <= cx_nx;
            cy_ff[i+1]   <= cy_nx;
            z_ff[i+1]    <= z_nx;
            zero_ff[i+1] <= zero_ff[i];
            n_ff[i+1]    <= n_nx;
            res_ff[i+1]  <= res_nx;
         end
      end
   end

   // Zero vector has angle zero
   assign angle = zero_ff[POLAR_STEPS] ? '0 : z_ff[POLAR_STEPS];
   assign mag   = res_ff[POLAR_STEPS][CW-1:0];

endmodule

`default_nettype wire

@@ rtl/pvi_rotate.sv @@
// Pipelined angle and magnitude blend followed by CORDIC rotation back to cartesian.
`default_nettype none

module pvi_rotate (
   input  logic                          clock,
   input  logic                          en,
   input  logic [pvi_pkg::AW-1:0]        a0,
   input  logic [pvi_pkg::AW-1:0]        a1,
   input  logic [pvi_pkg::CW-1:0]        r0,
   input  logic [pvi_pkg::CW-1:0]        r1,
   input  logic [pvi_pkg::TW-1:0]        t,
   output logic signed [pvi_pkg::DW-1:0] rot_x,
   output logic signed [pvi_pkg::DW-1:0] rot_y
);
   import pvi_pkg::*;

   localparam int PRW = CW + TW + 2;
   localparam logic signed [ZW-1:0] Q_S    = ZW'(64'sh4000_0000);
   localparam logic signed [ZW-1:0] HALF_S = ZW'(64'sh8000_0000);

   // Stage 1: products
   logic [AW-1:0]          d;
   logic [AW+TW-1:0]       pa;
   logic signed [CW:0]     rd;
   logic signed [PRW-1:0]  pr;
   logic [AW+TW-1:0]       pa_ff;
   logic signed [PRW-1:0]  pr_ff;
   logic [AW-1:0]          a0_ff;
   logic [CW-1:0]          r0_ff;

   always_comb begin
      d  = a1 - a0;
      pa = d * t;
      rd = $signed({1'b0, r1}) - $signed({1'b0, r0});
      pr = rd * $signed({1'b0, t});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa;
         pr_ff <= pr;
         a0_ff <= a0;
         r0_ff <= r0;
      end
   end

   // Stage 2: round and add
   logic [AW+TW-1:0]      pa_rnd;
   logic signed [PRW-1:0] pr_rnd;
   logic signed [CW+1:0]  r_sum;
   logic [AW-1:0]         ang_ff;
   logic [CW-1:0]         rm_ff;

   always_comb begin
      pa_rnd = pa_ff + (AW+TW)'(ROUND_HALF);
      pr_rnd = pr_ff + PRW'(ROUND_HALF);
      r_sum  = $signed({2'b00, r0_ff}) + $signed(pr_rnd[PRW-1:TW]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= a0_ff + pa_rnd[AW+TW-1:TW];
         rm_ff  <= r_sum[CW-1:0];
      end
   end

   // Stage 3: gain-corrected magnitude, fold angle into the right half plane
   logic [CW+KW-1:0]      prod;
   logic signed [ZW-1:0]  zs;
   logic signed [ZW-1:0]  z_adj;
   logic                  flip;
   logic signed [DW-1:0]  prod_ff;
   logic                  flip_ff;
   logic signed [ZW-1:0]  z3_ff;

   always_comb begin
      prod  = rm_ff * INV_GAIN;
      zs    = {{(ZW-AW){ang_ff[AW-1]}}, ang_ff};
      z_adj = zs;
      flip  = 1'b0;
      if (zs > Q_S) begin
         z_adj = zs - HALF_S;
         flip  = 1'b1;
      end else if (zs < -Q_S) begin
         z_adj = zs + HALF_S;
         flip  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= DW'(prod);
         flip_ff <= flip;
         z3_ff   <= z_adj;
      end
   end

   // Stage 4 and on: rotation
   logic signed [DW-1:0] cx_ff [STEPS+1];
   logic signed [DW-1:0] cy_ff [STEPS+1];
   logic signed [ZW-1:0] z_ff  [STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0] <= flip_ff ? -prod_ff : prod_ff;
         cy_ff[0] <= '0;
         z_ff[0]  <= z3_ff;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN_S = ZW'({2'b00, ATAN_TAB[i]});

      logic signed [DW-1:0] cx_nx;
      logic signed [DW-1:0] cy_nx;
      logic signed [ZW-1:0] z_nx;

      always_comb begin
         if (!z_ff[i][ZW-1]) begin
            cx_nx = cx_ff[i] - (cy_ff[i] >>> i);
            cy_nx = cy_ff[i] + (cx_ff[i] >>> i);
            z_nx  = z_ff[i] - ATAN_S;
         end else begin
            cx_nx = cx_ff[i] + (cy_ff[i] >>> i);
            cy_nx = cy_ff[i] - (cx_ff[i] >>> i);
            z_nx  = z_ff[i] + ATAN_S;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i+1] <= cx_nx;
            cy_ff[i+1] <= cy_nx;
            z_ff[i+1]  <= z_nx;
         end
      end
   end

   // Sine component gives x, cosine component gives y
   assign rot_x = cy_ff[STEPS];
   assign rot_y = cx_ff[STEPS];

endmodule

`default_nettype wire

@@ rtl/pvi_blend.sv @@
// Linear blend of coordinates and color channels, delayed to meet the polar path.
`default_nettype none

module pvi_blend (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [pvi_pkg::CW-1:0] x0,
   input  logic signed [pvi_pkg::CW-1:0] y0,
   input  logic signed [pvi_pkg::CW-1:0] z0,
   input  logic signed [pvi_pkg::CW-1:0] x1,
   input  logic signed [pvi_pkg::CW-1:0] y1,
   input  logic signed [pvi_pkg::CW-1:0] z1,
   input  logic [pvi_pkg::COLW-1:0]      c0,
   input  logic [pvi_pkg::COLW-1:0]      c1,
   input  logic [pvi_pkg::TW-1:0]        t,
   output pvi_pkg::lin_type              lin
);
   import pvi_pkg::*;

   localparam int PCW = CW + TW + 2;
   localparam int PHW = CHW + TW + 2;

   logic signed [CW-1:0]  ca [3];
   logic signed [CW-1:0]  cb [3];
   logic signed [CW:0]    cd [3];
   logic signed [PCW-1:0] cp [3];
   logic signed [CHW:0]   hd [NCH];
   logic signed [PHW-1:0] hp [NCH];

   logic signed [CW-1:0]  ca_ff [3];
   logic signed [PCW-1:0] cp_ff [3];
   logic [CHW-1:0]        ha_ff [NCH];
   logic signed [PHW-1:0] hp_ff [NCH];

   // Stage 1: differences times weight
   always_comb begin
      ca[0] = x0;
      ca[1] = y0;
      ca[2] = z0;
      cb[0] = x1;
      cb[1] = y1;
      cb[2] = z1;
      for (int k = 0; k < 3; k++) begin
         cd[k] = $signed({cb[k][CW-1], cb[k]}) - $signed({ca[k][CW-1], ca[k]});
         cp[k] = cd[k] * $signed({1'b0, t});
      end
      for (int k = 0; k < NCH; k++) begin
         hd[k] = $signed({1'b0, c1[k*CHW +: CHW]}) - $signed({1'b0, c0[k*CHW +: CHW]});
         hp[k] = hd[k] * $signed({1'b0, t});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            ca_ff[k] <= ca[k];
            cp_ff[k] <= cp[k];
         end
         for (int k = 0; k < NCH; k++) begin
            ha_ff[k] <= c0[k*CHW +: CHW];
            hp_ff[k] <= hp[k];
         end
      end
   end

   // Stage 2: round and add to the start value
   logic signed [PCW-1:0] c_rnd [3];
   logic signed [CW+1:0]  c_sum [3];
   logic signed [PHW-1:0] h_rnd [NCH];
   logic signed [CHW+1:0] h_sum [NCH];
   lin_type               lin_in;
   lin_type               dly_ff [LAT_CORE-1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_rnd[k] = cp_ff[k] + PCW'(ROUND_HALF);
         c_sum[k] = $signed({{2{ca_ff[k][CW-1]}}, ca_ff[k]}) + $signed(c_rnd[k][PCW-1:TW]);
      end
      lin_in.x = c_sum[0][CW-1:0];
      lin_in.y = c_sum[1][CW-1:0];
      lin_in.z = c_sum[2][CW-1:0];
      for (int k = 0; k < NCH; k++) begin
         h_rnd[k] = hp_ff[k] + PHW'(ROUND_HALF);
         h_sum[k] = $signed({2'b00, ha_ff[k]}) + $signed(h_rnd[k][PHW-1:TW]);
         lin_in.color[k*CHW +: CHW] = h_sum[k][CHW-1:0];
      end
   end

   // Advance the result alongside the polar path
   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= lin_in;
         for (int k = 1; k < LAT_CORE - 1; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   assign lin = dly_ff[LAT_CORE-2];

endmodule

`default_nettype wire

@@ rtl/polar_vertex_interpolator_unit.sv @@
// Top level of the polar vertex interpolator: channels, register, pipeline and output stage.
`default_nettype none

// Blends one start/end vertex pair per transfer by blend/65536. With blend_mode 0 x, y and z
// are blended linearly; with blend_mode 1 the xy position is blended in polar form
// (angle from the y axis, clockwise, and magnitude) and z is forced to 1.0. Colors are
// always blended per 8-bit channel, and clipped flags a saturated coordinate. The block
// takes one item per clock cycle while the response is not stalled; a result passes through
// the two 16-step CORDIC pipelines (vectoring with the square root beside it, then rotation)
// and the blend multiplier stages between them before the output register. A stalled
// response freezes the whole pipeline. blend_mode may be written only while no items are in
// flight; the register port is always ready.
module polar_vertex_interpolator_unit (
   input  logic     clock,
   input  logic     reset,
   pvi_req_if.sink  req_chan,
   pvi_rsp_if.source rsp_chan,
   pvi_csr_if.sink  csr_chan
);
   import pvi_pkg::*;

   logic blend_mode_ff;
   logic adv;

   // Register write
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         blend_mode_ff <= csr_chan.blend_mode;
      end
   end

   // Advance everything unless the response is held
   logic rsp_valid_ff;

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Input register
   logic signed [CW-1:0] sx_ff;
   logic signed [CW-1:0] sy_ff;
   logic signed [CW-1:0] sz_ff;
   logic signed [CW-1:0] ex_ff;
   logic signed [CW-1:0] ey_ff;
   logic signed [CW-1:0] ez_ff;
   logic [COLW-1:0]      sc_ff;
   logic [COLW-1:0]      ec_ff;
   logic [TW-1:0]        t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff <= req_chan.start_x;
         sy_ff <= req_chan.start_y;
         sz_ff <= req_chan.start_z;
         ex_ff <= req_chan.end_x;
         ey_ff <= req_chan.end_y;
         ez_ff <= req_chan.end_z;
         sc_ff <= req_chan.start_color;
         ec_ff <= req_chan.end_color;
         t_ff  <= req_chan.blend;
      end
   end

   // Valid bits, one per stage
   logic vld_ff [LAT_CORE+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAT_CORE; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_chan.valid;
         for (int k = 1; k <= LAT_CORE; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Carry the weight to the polar blend
   logic [TW-1:0] t_dly_ff [LAT_POLAR];

   always_ff @(posedge clock) begin
      if (adv) begin
         t_dly_ff[0] <= t_ff;
         for (int k = 1; k < LAT_POLAR; k++) begin
            t_dly_ff[k] <= t_dly_ff[k-1];
         end
      end
   end

   // Polar path
   logic [AW-1:0]        a0;
   logic [AW-1:0]        a1;
   logic [CW-1:0]        r0;
   logic [CW-1:0]        r1;
   logic signed [DW-1:0] rot_x;
   logic signed [DW-1:0] rot_y;
   lin_type              lin;

   pvi_polar u_polar_start (
      .clock (clock),
      .en    (adv),
      .x     (sx_ff),
      .y     (sy_ff),
      .angle (a0),
      .mag   (r0)
   );

   pvi_polar u_polar_end (
      .clock (clock),
      .en    (adv),
      .x     (ex_ff),
      .y     (ey_ff),
      .angle (a1),
      .mag   (r1)
   );

   pvi_rotate u_rotate (
      .clock (clock),
      .en    (adv),
      .a0    (a0),
      .a1    (a1),
      .r0    (r0),
      .r1    (r1),
      .t     (t_dly_ff[LAT_POLAR-1]),
      .rot_x (rot_x),
      .rot_y (rot_y)
   );

   pvi_blend u_blend (
      .clock (clock),
      .en    (adv),
      .x0    (sx_ff),
      .y0    (sy_ff),
      .z0    (sz_ff),
      .x1    (ex_ff),
      .y1    (ey_ff),
      .z1    (ez_ff),
      .c0    (sc_ff),
      .c1    (ec_ff),
      .t     (t_ff),
      .lin   (lin)
   );

   // Round out of CORDIC scale, saturate, pick the mode
   logic signed [DW-1:0] px;
   logic signed [DW-1:0] py;
   sat_type              sat_x;
   sat_type              sat_y;
   logic signed [CW-1:0] x_in;
   logic signed [CW-1:0] y_in;
   logic signed [CW-1:0] z_in;
   logic                 clip_in;

   always_comb begin
      px    = (rot_x + ROUND_SCALE) >>> SCALE_SH;
      py    = (rot_y + ROUND_SCALE) >>> SCALE_SH;
      sat_x = sat_coord(px);
      sat_y = sat_coord(py);
      if (blend_mode_ff) begin
         x_in    = sat_x.value;
         y_in    = sat_y.value;
         z_in    = Z_ONE.value;
         clip_in = sat_x.clip || sat_y.clip || Z_ONE.clip;
      end else begin
         x_in    = lin.x;
         y_in    = lin.y;
         z_in    = lin.z;
         clip_in = 1'b0;
      end
   end

   // Output register
   logic signed [CW-1:0] out_x_ff;
   logic signed [CW-1:0] out_y_ff;
   logic signed [CW-1:0] out_z_ff;
   logic [COLW-1:0]      out_color_ff;
   logic                 clipped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[LAT_CORE];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff     <= x_in;
         out_y_ff     <= y_in;
         out_z_ff     <= z_in;
         out_color_ff <= lin.color;
         clipped_ff   <= clip_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_x     = out_x_ff;
   assign rsp_chan.out_y     = out_y_ff;
   assign rsp_chan.out_z     = out_z_ff;
   assign rsp_chan.out_color = out_color_ff;
   assign rsp_chan.clipped   = clipped_ff;

endmodule

`default_nettype wire

@@ rtl/pvi_checker.sv @@
// Port-level assertions for the polar vertex interpolator and their binding to the top level.
`default_nettype none

module pvi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [pvi_pkg::CW-1:0] out_x,
   input logic signed [pvi_pkg::CW-1:0] out_y,
   input logic signed [pvi_pkg::CW-1:0] out_z,
   input logic [pvi_pkg::COLW-1:0]      out_color,
   input logic                          clipped
);
   import pvi_pkg::*;

   localparam logic signed [CW-1:0] HI = COORD_HI[CW-1:0];
   localparam logic signed [CW-1:0] LO = COORD_LO[CW-1:0];

   // Held response stays valid
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Held response keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
                                  && $stable(out_color) && $stable(clipped))
      else $error("response payload changed while stalled");

   // Reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Input never blocked while the output stage is free
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output stage");

   // Clip flag only with a coordinate at a range limit
   a_clip_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clipped |-> (out_x == HI) || (out_x == LO) || (out_y == HI)
                               || (out_y == LO) || (out_z == HI) || (out_z == LO))
      else $error("clip flag without saturated coordinate");

endmodule

bind polar_vertex_interpolator_unit pvi_checker u_pvi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_x     (rsp_chan.out_x),
   .out_y     (rsp_chan.out_y),
   .out_z     (rsp_chan.out_z),
   .out_color (rsp_chan.out_color),
   .clipped   (rsp_chan.clipped)
);

`default_nettype wire

@@ tb/polar_vertex_interpolator_unit_tb.sv @@
// Testbench for the polar vertex interpolator: directed and random vertex pairs, scoreboard.
`default_nettype none

module polar_vertex_interpolator_unit_tb;
   import pvi_pkg::*;

   localparam int DRAIN_CYCLES   = LAT_CORE + 8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;

   typedef enum logic {MIX_LINEAR = 1'b0, MIX_POLAR = 1'b1} mix_type;

   typedef struct {
      logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
      logic [COLW-1:0]      c0, c1;
      logic [TW-1:0]        t;
   } vertex_pair_type;

   typedef struct {
      logic signed [CW-1:0] x, y, z;
      logic [COLW-1:0]      color;
      logic                 clip;
   } vertex_out_type;

   // Predicts blended vertices and checks them against the block in order
   class blend_scoreboard;
      mix_type          blend_mode = MIX_LINEAR;
      vertex_out_type   pending_q[$];
      int               mismatches = 0;
      longint           inv_k;

      function new();
         longint unsigned p, s;
         p = 64'd1 << 60;
         for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
         s = int_sqrt(p);
         inv_k = ((64'd1 << 60) + s / 2) / s;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n    = n - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      function longint lerp(longint a, longint b, longint t);
         return a + (((b - a) * t + 32768) >>> 16);
      endfunction

      // Angle from the y axis in binary angle units
      function logic [31:0] to_angle(longint x, longint y);
         longint cx, cy, tx, dx, dy;
         logic [31:0] z;
         cx = y <<< SCALE_SH;
         cy = x <<< SCALE_SH;
         z  = 0;
         if (x == 0 && y == 0) return 0;
         if (cx < 0) begin
            tx = cx;
            if (cy >= 0) begin
               cx = cy; cy = -tx; z = QUARTER_TURN;
            end else begin
               cx = -cy; cy = tx; z = THREE_QUARTER;
            end
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
               cx += dx; cy -= dy; z += ATAN_TAB[i];
            end else begin
               cx -= dx; cy += dy; z -= ATAN_TAB[i];
            end
         end
         return z;
      endfunction

      function longint clamp(longint v, ref logic clip);
         if (v > 32767) begin clip = 1'b1; return 32767; end
         if (v < -32768) begin clip = 1'b1; return -32768; end
         return v;
      endfunction

      function void note_request(vertex_pair_type v);
         vertex_out_type o;
         longint t, rx, ry, rz, r0, r1, cx, cy, z, dx, dy;
         logic [31:0] a0, a1, d, ang;
         logic clip;
         t    = longint'(v.t);
         clip = 1'b0;
         if (blend_mode == MIX_LINEAR) begin
            rx = lerp(v.sx, v.ex, t);
            ry = lerp(v.sy, v.ey, t);
            rz = lerp(v.sz, v.ez, t);
         end else begin
            a0  = to_angle(v.sx, v.sy);
            a1  = to_angle(v.ex, v.ey);
            d   = a1 - a0;
            ang = a0 + 32'((longint'(d) * t + 32768) >> 16);
            r0  = int_sqrt(longint'(v.sx) * v.sx + longint'(v.sy) * v.sy);
            r1  = int_sqrt(longint'(v.ex) * v.ex + longint'(v.ey) * v.ey);
            // rotate (r, 0) back to the blended angle
            cx  = lerp(r0, r1, t) * inv_k;
            cy  = 0;
            z   = longint'($signed(ang));
            if (z > longint'(QUARTER_TURN)) begin
               cx = -cx; z -= 64'h8000_0000;
            end else if (z < -longint'(QUARTER_TURN)) begin
               cx = -cx; z += 64'h8000_0000;
            end
            for (int i = 0; i < STEPS; i++) begin
               dx = cy >>> i;
               dy = cx >>> i;
               if (z >= 0) begin
                  cx -= dx; cy += dy; z -= ATAN_TAB[i];
               end else begin
                  cx += dx; cy -= dy; z += ATAN_TAB[i];
               end
            end
            rx = (cy + (longint'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
            ry = (cx + (longint'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
            rz = 64'd1 << FB;
         end
         o.x = CW'(clamp(rx, clip));
         o.y = CW'(clamp(ry, clip));
         o.z = CW'(clamp(rz, clip));
         for (int k = 0; k < NCH; k++)
            o.color[CHW*k +: CHW] = CHW'(lerp(v.c0[CHW*k +: CHW], v.c1[CHW*k +: CHW], t));
         o.clip = clip;
         pending_q.push_back(o);
      endfunction

      function void check_result(vertex_out_type a);
         vertex_out_type e;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", a.x, a.y);
            return;
         end
         e = pending_q.pop_front();
         if (a.x !== e.x || a.y !== e.y || a.z !== e.z || a.color !== e.color ||
             a.clip !== e.clip) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch exp x=%0d y=%0d z=%0d c=%h clip=%b",
                         " got x=%0d y=%0d z=%0d c=%h clip=%b"},
                        e.x, e.y, e.z, e.color, e.clip, a.x, a.y, a.z, a.color, a.clip);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   pvi_req_if req_chan();
   pvi_rsp_if rsp_chan();
   pvi_csr_if csr_chan();
   blend_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req      = 0;
   int hold_done     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   polar_vertex_interpolator_unit dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan));

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.start_x = '0; req_chan.start_y = '0; req_chan.start_z = '0;
      req_chan.end_x = '0; req_chan.end_y = '0; req_chan.end_z = '0;
      req_chan.start_color = '0; req_chan.end_color = '0; req_chan.blend = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.blend_mode = 1'b0;
   end

   // Drive response ready: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_req != hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = hold_req;
      end
      if (hold_left > 0) begin
         rsp_chan.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_chan.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Observe transfers and guard against a hang
   always @(posedge clock) begin
      vertex_pair_type v;
      vertex_out_type  o;
      if (!reset) begin
         quiet_cycles++;
         if (req_chan.valid && req_chan.ready) begin
            v.sx = req_chan.start_x; v.sy = req_chan.start_y; v.sz = req_chan.start_z;
            v.ex = req_chan.end_x; v.ey = req_chan.end_y; v.ez = req_chan.end_z;
            v.c0 = req_chan.start_color; v.c1 = req_chan.end_color; v.t = req_chan.blend;
            sb.note_request(v);
            quiet_cycles = 0;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            o.x = rsp_chan.out_x; o.y = rsp_chan.out_y; o.z = rsp_chan.out_z;
            o.color = rsp_chan.out_color; o.clip = rsp_chan.clipped;
            sb.check_result(o);
            quiet_cycles = 0;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            sb.blend_mode = mix_type'(csr_chan.blend_mode);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Offer one vertex pair after a random gap; called and returning at a falling edge
   task automatic send_pair(vertex_pair_type v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.start_x = v.sx; req_chan.start_y = v.sy; req_chan.start_z = v.sz;
      req_chan.end_x = v.ex; req_chan.end_y = v.ey; req_chan.end_z = v.ez;
      req_chan.start_color = v.c0; req_chan.end_color = v.c1; req_chan.blend = v.t;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Drain the pipeline, then write the blend style
   task automatic set_mix(mix_type m);
      req_chan.valid = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.blend_mode = m;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   function automatic vertex_pair_type pair(int sx, int sy, int sz, int ex, int ey, int ez,
                                            logic [31:0] c0, logic [31:0] c1, int t);
      vertex_pair_type v;
      v.sx = CW'(sx); v.sy = CW'(sy); v.sz = CW'(sz);
      v.ex = CW'(ex); v.ey = CW'(ey); v.ez = CW'(ez);
      v.c0 = c0; v.c1 = c1; v.t = TW'(t);
      return v;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return CW'($urandom_range(0, 8192)) - CW'(4096);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         2: return CW'($urandom_range(0, 64)) - CW'(32);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic vertex_pair_type rand_pair();
      vertex_pair_type v;
      v.sx = rand_coord(); v.sy = rand_coord(); v.sz = rand_coord();
      v.ex = rand_coord(); v.ey = rand_coord(); v.ez = rand_coord();
      v.c0 = $urandom; v.c1 = $urandom;
      case ($urandom_range(0, 7))
         0: v.t = '0;
         1: v.t = '1;
         default: v.t = TW'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0) begin
         v.ex = '0; v.ey = '0;
      end
      return v;
   endfunction

   task automatic run_directed();
      send_pair(pair(0, 0, 0, 0, 0, 0, 32'h0, 32'hFFFFFFFF, 0));
      send_pair(pair(32767, 32767, 32767, -32768, -32768, -32768,
                     32'hFFFFFFFF, 32'h0, 65535));
      send_pair(pair(-32768, -32768, -32768, 32767, 32767, 32767,
                     32'h00FF00FF, 32'hFF00FF00, 32768));
      send_pair(pair(4096, 0, 0, 0, 4096, 4096, 32'h12345678, 32'h87654321, 16384));
      send_pair(pair(0, 4096, 100, 4096, 0, -100, 32'h80808080, 32'h7F7F7F7F, 1));
      send_pair(pair(0, -4096, 0, -4096, 0, 0, 32'hA5A5A5A5, 32'h5A5A5A5A, 49152));
      send_pair(pair(-4096, 0, 0, 0, -4096, 0, 32'h01020304, 32'hFEFDFCFB, 65535));
      send_pair(pair(-3000, -3000, 0, 3000, -3000, 0, 32'h0, 32'h0, 32768));
      send_pair(pair(0, 0, 0, 20000, 20000, 0, 32'h0, 32'h10203040, 40000));
      send_pair(pair(32767, -32768, 0, -32768, 32767, 0, 32'hFF00FF00, 32'h0, 32768));
      send_pair(pair(-32768, 0, 0, 0, 32767, 0, 32'h0, 32'hFFFFFFFF, 65535));
      send_pair(pair(1, 1, 1, -1, -1, -1, 32'h7FFFFFFF, 32'h80000000, 12345));
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_pair(rand_pair());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed cases in both styles, default style first
      send_idle_pct = 35; recv_idle_pct = 73;
      run_directed();
      set_mix(MIX_POLAR);
      run_directed();

      // random segments across idle profiles and styles
      run_random(180);
      set_mix(MIX_LINEAR);
      hold_req++;
      run_random(180);
      send_idle_pct = 73; recv_idle_pct = 35;
      set_mix(MIX_POLAR);
      run_random(180);
      set_mix(MIX_LINEAR);
      run_random(180);
      send_idle_pct = 0; recv_idle_pct = 0;
      set_mix(MIX_POLAR);
      hold_req++;
      run_random(180);
      set_mix(MIX_LINEAR);
      run_random(90);
      set_mix(MIX_POLAR);
      run_random(90);

      // drain and finish
      req_chan.valid = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
